// ----- rtl/boundary_tag_table_allocator_top_defines.svh -----
// Assertion macros for the boundary tag table allocator.
// Included by the top level; no other dependencies.
`ifndef BOUNDARY_TAG_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`define BOUNDARY_TAG_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define BTTA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");
`define BTTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");
`else
`define BTTA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BTTA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/btta_pkg.sv -----
// Shared types and default constants for the boundary tag table allocator.
// No dependencies.
package btta_pkg;
   localparam int TABLE_ELEMS_DEF   = 1024;
   localparam int FRAC_BITS_DEF     = 3;
   localparam int TOP_BINS_DEF      = 8;
   localparam int MAX_REQUEST_DEF   = 1024;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_DOUBLE_FREE = 2'd2,
      ST_BAD_SIZE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_ADD_DEC
   } alu_op_type;

   typedef enum logic [1:0] {
      MASK_KEEP,
      MASK_SET,
      MASK_CLEAR
   } mask_op_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_FIND, S_A_HEAD, S_A_SIZE, S_A_FIT, S_A_POP, S_A_MARK, S_A_REM, S_A_REM2,
      S_F0, S_F1, S_F2,
      S_R0, S_R1, S_R2, S_R3, S_RN0, S_RN1, S_RN2,
      S_U0, S_U1,
      S_DONE
   } state_type;
endpackage

// ----- rtl/boundary_tag_table_allocator_top.sv -----
// Top level of the two-level segregated-fit region allocator.
// Depends on btta_pkg, btta_alu, btta_class and the defines header.
//
// Usage:
//   Command channel: drive req_operation, req_size and req_release_offset and
//   raise start; the item is taken at a rising edge with start high and busy
//   low. busy stays high until the result has been shown.
//   Result channel: rsp_valid is high for exactly one cycle with
//   rsp_region_offset and rsp_status; the receiver cannot stall it.
//   Sequencing: a sequencer walks the node memories (region size, next/prev
//   links, boundary marks) and the bin head memory, one access group per
//   cycle, with one shared adder for every address and size computation.
//   The next item is taken only after the strobe, once the sequencer has
//   returned to idle.
//   Reset: masks reset at once, then a clearing pass over all TABLE_ELEMS
//   entries writes region sizes, boundary marks, list links and bin heads;
//   busy is high during it.
`include "boundary_tag_table_allocator_top_defines.svh"
module boundary_tag_table_allocator_top import btta_pkg::*; #(
   parameter int TABLE_ELEMS   = TABLE_ELEMS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int TOP_BINS      = TOP_BINS_DEF,
   parameter int MAX_REQUEST   = MAX_REQUEST_DEF,
   localparam int AW           = $clog2(TABLE_ELEMS),
   localparam int SW           = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_operation,
   input  logic [SW-1:0] req_size,
   input  logic [AW-1:0] req_release_offset,
   output logic          rsp_valid,
   output logic [AW-1:0] rsp_region_offset,
   output status_type    rsp_status
);
   localparam int W        = SW + 1;
   localparam int MB       = FRAC_BITS;
   localparam int LEAF     = 1 << MB;
   localparam int TW       = $clog2(TOP_BINS);
   localparam int BW       = TW + MB;
   localparam int NUM_BINS = TOP_BINS * LEAF;
   localparam logic [SW-1:0] NIL       = SW'(TABLE_ELEMS);
   localparam logic [W:0]    NIL_X     = (W+1)'(TABLE_ELEMS);
   localparam logic [AW-1:0] LAST_ELEM = AW'(TABLE_ELEMS - 1);
   localparam logic [BW-1:0] LAST_BIN  = BW'(NUM_BINS - 1);
   localparam logic [TOP_BINS-1:0] TOP_MASK_RST   = {1'b1, {(TOP_BINS-1){1'b0}}};
   localparam logic [NUM_BINS-1:0] LEAF_MASKS_RST = {1'b1, {(NUM_BINS-1){1'b0}}};

   // memories
   logic [SW-1:0] rs_mem_ff [TABLE_ELEMS];
   logic [SW-1:0] nx_mem_ff [TABLE_ELEMS];
   logic [SW-1:0] pv_mem_ff [TABLE_ELEMS];
   logic          bu_mem_ff [TABLE_ELEMS];
   logic [SW-1:0] bh_mem_ff [NUM_BINS];
   logic [SW-1:0] rs_rd_ff, nx_rd_ff, pv_rd_ff, bh_rd_ff;
   logic          bu_rd_ff;
   logic          rs_we, nx_we, pv_we, bu_we, bh_we;
   logic [AW-1:0] rs_wa, nx_wa, pv_wa, bu_wa, rs_ra, nx_ra, pv_ra, bu_ra;
   logic [BW-1:0] bh_wa, bh_ra;
   logic [SW-1:0] rs_wd, nx_wd, pv_wd, bh_wd;
   logic          bu_wd;

   // sequencer state
   state_type     state_ff, state_in, ret_ff, ret_in;
   op_type        op_ff, op_in;
   status_type    status_ff, status_in;
   logic [SW-1:0] size_ff, size_in, orig_ff, orig_in, next_ff, next_in, old_ff, old_in;
   logic [AW-1:0] node_ff, node_in, un_ff, un_in, offset_ff, offset_in, clr_ff, clr_in;
   logic [BW-1:0] bin_ff, bin_in;
   logic [TOP_BINS-1:0]           top_mask_ff, top_mask_in;
   logic [TOP_BINS-1:0][LEAF-1:0] leaf_masks_ff, leaf_masks_in;

   // shared units
   alu_op_type    alu_op;
   logic [W-1:0]  alu_a, alu_b;
   logic [W:0]    alu_res;
   logic          alu_neg;
   logic [SW-1:0] cls_size;
   logic          cls_round;
   logic [BW-1:0] cls_bin;
   mask_op_type   mask_op;
   logic [BW-1:0] mask_bin;

   // bin search
   logic [TW-1:0] mtop, up_idx;
   logic [MB-1:0] mleaf, hit_leaf_idx, up_leaf_idx;
   logic          hit_leaf, up_hit, up_leaf_hit, fnd_ok;
   logic [BW-1:0] fnd_bin;

   logic          size_bad;
   logic [SW-1:0] link_next, bh_old;

   btta_alu #(.W(W)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );
   assign alu_neg = alu_res[W];

   btta_class #(.SW(SW), .MB(MB), .NUM_BINS(NUM_BINS), .BW(BW)) u_class (
      .size     (cls_size),
      .round_up (cls_round),
      .bin      (cls_bin)
   );

   assign size_bad  = (size_ff == '0) || (32'(size_ff) > MAX_REQUEST);
   // clamp corrupt links to the end marker
   assign link_next = (nx_rd_ff > NIL) ? NIL : nx_rd_ff;
   assign bh_old    = (bh_rd_ff >= NIL) ? NIL : bh_rd_ff;

   // find-first-set over the leaf mask of the minimum class, else a higher top
   always_comb begin
      mtop         = cls_bin[BW-1:MB];
      mleaf        = cls_bin[MB-1:0];
      hit_leaf     = 1'b0;
      hit_leaf_idx = '0;
      for (int l = LEAF - 1; l >= 0; l--) begin
         if (MB'(l) >= mleaf && leaf_masks_ff[mtop][l]) begin
            hit_leaf     = 1'b1;
            hit_leaf_idx = MB'(l);
         end
      end
      hit_leaf = hit_leaf && top_mask_ff[mtop];
      up_hit = 1'b0;
      up_idx = '0;
      for (int t = TOP_BINS - 1; t >= 0; t--) begin
         if (TW'(t) > mtop && top_mask_ff[t]) begin
            up_hit = 1'b1;
            up_idx = TW'(t);
         end
      end
      up_leaf_hit = 1'b0;
      up_leaf_idx = '0;
      for (int l = LEAF - 1; l >= 0; l--) begin
         if (leaf_masks_ff[up_idx][l]) begin
            up_leaf_hit = 1'b1;
            up_leaf_idx = MB'(l);
         end
      end
      fnd_ok  = hit_leaf || (up_hit && up_leaf_hit);
      fnd_bin = hit_leaf ? {mtop, hit_leaf_idx} : {up_idx, up_leaf_idx};
   end

   // bin bitmask update: set marks a bin non-empty, clear drops it and its top if empty
   always_comb begin
      top_mask_in   = top_mask_ff;
      leaf_masks_in = leaf_masks_ff;
      unique case (mask_op)
         MASK_KEEP: begin
         end
         MASK_SET: begin
            leaf_masks_in[mask_bin[BW-1:MB]][mask_bin[MB-1:0]] = 1'b1;
            top_mask_in[mask_bin[BW-1:MB]] = 1'b1;
         end
         MASK_CLEAR: begin
            leaf_masks_in[mask_bin[BW-1:MB]][mask_bin[MB-1:0]] = 1'b0;
            if (leaf_masks_in[mask_bin[BW-1:MB]] == '0) top_mask_in[mask_bin[BW-1:MB]] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         top_mask_ff   <= TOP_MASK_RST;
         leaf_masks_ff <= LEAF_MASKS_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         top_mask_ff   <= top_mask_in;
         leaf_masks_ff <= leaf_masks_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      orig_ff   <= orig_in;
      next_ff   <= next_in;
      old_ff    <= old_in;
      node_ff   <= node_in;
      un_ff     <= un_in;
      offset_ff <= offset_in;
      bin_ff    <= bin_in;
   end

   // memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (rs_we) rs_mem_ff[rs_wa] <= rs_wd;
      rs_rd_ff <= rs_mem_ff[rs_ra];
   end
   always_ff @(posedge clock) begin
      if (nx_we) nx_mem_ff[nx_wa] <= nx_wd;
      nx_rd_ff <= nx_mem_ff[nx_ra];
   end
   always_ff @(posedge clock) begin
      if (pv_we) pv_mem_ff[pv_wa] <= pv_wd;
      pv_rd_ff <= pv_mem_ff[pv_ra];
   end
   always_ff @(posedge clock) begin
      if (bu_we) bu_mem_ff[bu_wa] <= bu_wd;
      bu_rd_ff <= bu_mem_ff[bu_ra];
   end
   always_ff @(posedge clock) begin
      if (bh_we) bh_mem_ff[bh_wa] <= bh_wd;
      bh_rd_ff <= bh_mem_ff[bh_ra];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      op_in     = op_ff;
      status_in = status_ff;
      size_in   = size_ff;
      orig_in   = orig_ff;
      next_in   = next_ff;
      old_in    = old_ff;
      node_in   = node_ff;
      un_in     = un_ff;
      offset_in = offset_ff;
      bin_in    = bin_ff;
      clr_in    = clr_ff;
      rs_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; bu_we = 1'b0; bh_we = 1'b0;
      rs_wa = node_ff; nx_wa = node_ff; pv_wa = node_ff; bu_wa = node_ff; bh_wa = bin_ff;
      rs_wd = size_ff; nx_wd = NIL; pv_wd = NIL; bu_wd = 1'b0; bh_wd = NIL;
      rs_ra = node_ff; nx_ra = node_ff; pv_ra = node_ff; bu_ra = node_ff; bh_ra = bin_ff;
      alu_op    = ALU_ADD;
      alu_a     = W'(node_ff);
      alu_b     = W'(size_ff);
      cls_size  = size_ff;
      cls_round = 1'b0;
      mask_op   = MASK_KEEP;
      mask_bin  = bin_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep sizes, marks, links and bin heads to the single free region
            rs_we = 1'b1;
            rs_wa = clr_ff;
            rs_wd = (clr_ff == '0 || clr_ff == LAST_ELEM) ? NIL : '0;
            bu_we = 1'b1;
            bu_wa = clr_ff;
            bu_wd = 1'b0;
            nx_we = 1'b1;
            nx_wa = clr_ff;
            nx_wd = NIL;
            pv_we = 1'b1;
            pv_wa = clr_ff;
            pv_wd = NIL;
            if (32'(clr_ff) < NUM_BINS) begin
               bh_we = 1'b1;
               bh_wa = clr_ff[BW-1:0];
               bh_wd = (clr_ff[BW-1:0] == LAST_BIN) ? '0 : NIL;
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ELEM) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_operation);
               size_in   = req_size;
               node_in   = req_release_offset;
               offset_in = '0;
               status_in = ST_OK;
               state_in  = (op_type'(req_operation) == OP_RELEASE) ? S_R0 : S_A_FIND;
            end
         end
         S_A_FIND: begin
            cls_round = 1'b1;
            bin_in    = fnd_bin;
            bh_ra     = fnd_bin;
            if (size_bad) begin
               status_in = ST_BAD_SIZE;
               state_in  = S_DONE;
            end else if (top_mask_ff == '0 || !fnd_ok) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               state_in = S_A_HEAD;
            end
         end
         S_A_HEAD: begin
            node_in = bh_rd_ff[AW-1:0];
            rs_ra   = bh_rd_ff[AW-1:0];
            nx_ra   = bh_rd_ff[AW-1:0];
            if (bh_rd_ff >= NIL) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               state_in = S_A_SIZE;
            end
         end
         S_A_SIZE: begin
            // head of the clamped last bin may still be too small
            alu_op  = ALU_SUB;
            alu_a   = W'(rs_rd_ff);
            alu_b   = W'(size_ff);
            orig_in = rs_rd_ff;
            next_in = link_next;
            if (alu_neg) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               state_in = S_A_FIT;
            end
         end
         S_A_FIT: begin
            alu_b = W'(orig_ff);
            if (alu_res > NIL_X) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               state_in = S_A_POP;
            end
         end
         S_A_POP: begin
            bh_we = 1'b1;
            bh_wd = next_ff;
            if (next_ff != NIL) begin
               pv_we = 1'b1;
               pv_wa = next_ff[AW-1:0];
               pv_wd = NIL;
            end else begin
               mask_op = MASK_CLEAR;
            end
            bu_we     = 1'b1;
            bu_wd     = 1'b1;
            offset_in = node_ff;
            state_in  = S_A_MARK;
         end
         S_A_MARK: begin
            alu_op = ALU_ADD_DEC;
            if (size_ff > SW'(1)) begin
               bu_we = 1'b1;
               bu_wa = alu_res[AW-1:0];
               bu_wd = 1'b1;
            end
            state_in = S_A_REM;
         end
         S_A_REM: begin
            node_in  = alu_res[AW-1:0];
            state_in = S_A_REM2;
         end
         S_A_REM2: begin
            alu_op = ALU_SUB;
            alu_a  = W'(orig_ff);
            if (alu_res != '0) begin
               size_in  = alu_res[SW-1:0];
               state_in = S_F0;
            end else begin
               state_in = S_DONE;
            end
         end
         S_F0: begin
            // add free region: head marks, then fetch the bin head
            bin_in = cls_bin;
            bh_ra  = cls_bin;
            bu_we  = 1'b1;
            bu_wd  = 1'b0;
            rs_we  = 1'b1;
            state_in = S_F1;
         end
         S_F1: begin
            alu_op = ALU_ADD_DEC;
            if (size_ff > SW'(1)) begin
               bu_we = 1'b1;
               bu_wa = alu_res[AW-1:0];
               bu_wd = 1'b0;
               rs_we = 1'b1;
               rs_wa = alu_res[AW-1:0];
            end
            if (bh_rd_ff >= NIL) mask_op = MASK_SET;
            pv_we    = 1'b1;
            pv_wd    = NIL;
            nx_we    = 1'b1;
            nx_wd    = bh_old;
            old_in   = bh_old;
            state_in = S_F2;
         end
         S_F2: begin
            if (old_ff != NIL) begin
               pv_we = 1'b1;
               pv_wa = old_ff[AW-1:0];
               pv_wd = SW'(node_ff);
            end
            bh_we    = 1'b1;
            bh_wd    = SW'(node_ff);
            state_in = S_DONE;
         end
         S_R0: begin
            if (size_bad || alu_res > NIL_X) begin
               status_in = ST_BAD_SIZE;
               state_in  = S_DONE;
            end else begin
               state_in = S_R1;
            end
         end
         S_R1: begin
            alu_op = ALU_SUB;
            alu_b  = W'(1);
            rs_ra  = alu_res[AW-1:0];
            bu_ra  = alu_res[AW-1:0];
            if (!bu_rd_ff) begin
               status_in = ST_DOUBLE_FREE;
               state_in  = S_DONE;
            end else if (node_ff != '0) begin
               state_in = S_R2;
            end else begin
               state_in = S_RN0;
            end
         end
         S_R2: begin
            // merge with a free left neighbor whose size stays inside the table
            alu_op  = ALU_SUB;
            alu_b   = W'(rs_rd_ff);
            orig_in = rs_rd_ff;
            un_in   = alu_res[AW-1:0];
            if (!bu_rd_ff && rs_rd_ff != '0 && !alu_neg) state_in = S_R3;
            else state_in = S_RN0;
         end
         S_R3: begin
            alu_a    = W'(size_ff);
            alu_b    = W'(orig_ff);
            size_in  = alu_res[SW-1:0];
            node_in  = un_ff;
            ret_in   = S_RN0;
            state_in = S_U0;
         end
         S_RN0: begin
            un_in = alu_res[AW-1:0];
            rs_ra = alu_res[AW-1:0];
            bu_ra = alu_res[AW-1:0];
            if (alu_res < NIL_X) state_in = S_RN1;
            else state_in = S_F0;
         end
         S_RN1: begin
            alu_a   = W'(un_ff);
            alu_b   = W'(rs_rd_ff);
            orig_in = rs_rd_ff;
            if (!bu_rd_ff && rs_rd_ff != '0 && alu_res <= NIL_X) state_in = S_RN2;
            else state_in = S_F0;
         end
         S_RN2: begin
            alu_a    = W'(size_ff);
            alu_b    = W'(orig_ff);
            size_in  = alu_res[SW-1:0];
            ret_in   = S_F0;
            state_in = S_U0;
         end
         S_U0: begin
            pv_ra    = un_ff;
            nx_ra    = un_ff;
            rs_ra    = un_ff;
            state_in = S_U1;
         end
         S_U1: begin
            // unlink: splice neighbors, or drop the list head of its bin
            cls_size = rs_rd_ff;
            mask_bin = cls_bin;
            if (pv_rd_ff < NIL) begin
               nx_we = 1'b1;
               nx_wa = pv_rd_ff[AW-1:0];
               nx_wd = link_next;
               if (link_next != NIL) begin
                  pv_we = 1'b1;
                  pv_wa = link_next[AW-1:0];
                  pv_wd = pv_rd_ff;
               end
            end else begin
               bh_we = 1'b1;
               bh_wa = cls_bin;
               bh_wd = link_next;
               if (link_next != NIL) begin
                  pv_we = 1'b1;
                  pv_wa = link_next[AW-1:0];
                  pv_wd = NIL;
               end else begin
                  mask_op = MASK_CLEAR;
               end
            end
            state_in = ret_ff;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_DONE);
   assign rsp_status        = status_ff;
   assign rsp_region_offset = (status_ff == ST_OK && op_ff == OP_ALLOC) ? offset_ff : '0;

   `BTTA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `BTTA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy)
   `BTTA_ASSERT_IMPL(a_fail_offset, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_region_offset == '0)
endmodule

// ----- rtl/btta_alu.sv -----
// Shared adder/subtractor of the allocator sequencer.
// Depends on btta_pkg.
module btta_alu import btta_pkg::*; #(
   parameter int W = 12
) (
   input  alu_op_type     op,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [W:0]     res
);
   always_comb begin
      unique case (op)
         ALU_ADD:     res = {1'b0, a} + {1'b0, b};
         ALU_SUB:     res = {1'b0, a} - {1'b0, b};
         ALU_ADD_DEC: res = {1'b0, a} + {1'b0, b} - (W+1)'(1);
         default:     res = '0;
      endcase
   end
endmodule

// ----- rtl/btta_class.sv -----
// Size class encoder: small float with MB mantissa bits, clamped to the last bin.
// Depends on nothing but its parameters.
module btta_class #(
   parameter int SW       = 11,
   parameter int MB       = 3,
   parameter int NUM_BINS = 64,
   parameter int BW       = 6
) (
   input  logic [SW-1:0] size,
   input  logic          round_up,
   output logic [BW-1:0] bin
);
   localparam int LEAF = 1 << MB;
   localparam int HW   = $clog2(SW);
   localparam int CW   = (HW + MB + 2 > BW + 1) ? HW + MB + 2 : BW + 1;

   logic [HW-1:0] hb;
   logic [HW-1:0] start_pos;
   logic [SW-1:0] shifted;
   logic [SW-1:0] low_mask;
   logic          frac;
   logic [CW-1:0] full;

   always_comb begin
      hb = '0;
      for (int i = 0; i < SW; i++) begin
         if (size[i]) hb = HW'(i);
      end
      start_pos = hb - HW'(MB);
      shifted   = size >> start_pos;
      low_mask  = (SW'(1) << start_pos) - SW'(1);
      frac      = |(size & low_mask);
      if (size < SW'(LEAF)) begin
         full = CW'(size);
      end else begin
         full = ((CW'(start_pos) + CW'(1)) << MB) + CW'(shifted[MB-1:0])
              + CW'(round_up && frac);
      end
      bin = (full >= CW'(NUM_BINS)) ? BW'(NUM_BINS - 1) : full[BW-1:0];
   end
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for boundary_tag_table_allocator_top: a segregated-fit
// predictor checks every allocate and release result. Depends on btta_pkg and the RTL.
module testbench;
   import btta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ELEMS      = 1024;
   localparam int LEAVES     = 8;
   localparam int TOPS       = 8;
   localparam int BINS       = TOPS * LEAVES;
   localparam int NIL_LINK   = ELEMS;
   localparam int MAX_LEN    = 1024;
   localparam int CYCLE_CAP  = 400000;

   typedef struct {
      logic [9:0] offset;
      status_type status;
   } outcome_type;

   typedef struct {
      int base;
      int len;
   } grant_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [10:0] req_size;
   logic [9:0]  req_release_offset;
   logic        rsp_valid;
   logic [9:0]  rsp_region_offset;
   status_type  rsp_status;

   // allocator shadow state
   bit [7:0]  top_bits;
   bit [7:0]  leaf_bits [TOPS];
   int        bin_head [BINS];
   int        span_len [ELEMS];
   int        link_next [ELEMS];
   int        link_prev [ELEMS];
   bit        taken [ELEMS];

   outcome_type pending_outcomes [$];
   grant_type   live_grants [$];
   outcome_type seen;
   int       error_count;
   int       cycle_count;
   int       idle_pct;

   boundary_tag_table_allocator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_size           (req_size),
      .req_release_offset (req_release_offset),
      .rsp_valid          (rsp_valid),
      .rsp_region_offset  (rsp_region_offset),
      .rsp_status         (rsp_status)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Size class: small float with 3 mantissa bits, clamped to the last bin.
   function automatic int size_bin(int len, bit round_up);
      int hb;
      int lo;
      int mant;
      int bin;
      if (len < LEAVES) begin
         bin = len;
      end else begin
         hb = 0;
         while (hb < 31 && (len >> (hb + 1)) != 0) hb++;
         lo = hb - 3;
         mant = (len >> lo) & (LEAVES - 1);
         if (round_up && (len & ((1 << lo) - 1)) != 0) mant++;
         bin = ((lo + 1) << 3) + mant;
      end
      return (bin < BINS) ? bin : BINS - 1;
   endfunction

   function automatic int first_set(int mask, int from, int lim);
      for (int i = from; i < lim; i++) begin
         if ((mask >> i) & 1) return i;
      end
      return lim;
   endfunction

   function automatic void drop_bin_bit(int bin);
      int t;
      t = bin >> 3;
      leaf_bits[t][bin & 7] = 1'b0;
      if (leaf_bits[t] == 0) top_bits[t] = 1'b0;
   endfunction

   function automatic void push_free(int node, int len);
      int bin;
      int old;
      bin = size_bin(len, 1'b0);
      old = bin_head[bin];
      taken[node] = 1'b0;
      span_len[node] = len;
      if (len > 1) begin
         taken[node + len - 1] = 1'b0;
         span_len[node + len - 1] = len;
      end
      if (old >= NIL_LINK) begin
         old = NIL_LINK;
         leaf_bits[bin >> 3][bin & 7] = 1'b1;
         top_bits[bin >> 3] = 1'b1;
      end
      link_prev[node] = NIL_LINK;
      link_next[node] = old;
      if (old != NIL_LINK) link_prev[old] = node;
      bin_head[bin] = node;
   endfunction

   function automatic void pull_free(int node);
      int p;
      int n;
      int bin;
      p = link_prev[node];
      n = link_next[node];
      if (n > NIL_LINK) n = NIL_LINK;
      if (p < NIL_LINK) begin
         link_next[p] = n;
         if (n != NIL_LINK) link_prev[n] = p;
      end else begin
         bin = size_bin(span_len[node], 1'b0);
         bin_head[bin] = n;
         if (n != NIL_LINK) link_prev[n] = NIL_LINK;
         else drop_bin_bit(bin);
      end
   endfunction

   function automatic void clear_shadow();
      top_bits = '0;
      for (int i = 0; i < TOPS; i++) leaf_bits[i] = '0;
      for (int i = 0; i < BINS; i++) bin_head[i] = NIL_LINK;
      for (int i = 0; i < ELEMS; i++) begin
         span_len[i] = 0;
         link_next[i] = 0;
         link_prev[i] = 0;
         taken[i] = 1'b0;
      end
      push_free(0, ELEMS);
   endfunction

   function automatic status_type grant_region(int len, output int node);
      int minb;
      int mtop;
      int t;
      int leaf;
      int bin;
      int whole;
      int n;
      node = 0;
      if (len == 0 || len > MAX_LEN) return ST_BAD_SIZE;
      if (top_bits == 0) return ST_NO_SPACE;
      minb = size_bin(len, 1'b1);
      mtop = minb >> 3;
      t = mtop;
      leaf = LEAVES;
      if (top_bits[t]) leaf = first_set(leaf_bits[t], minb & 7, LEAVES);
      if (leaf >= LEAVES) begin
         t = first_set(top_bits, mtop + 1, TOPS);
         if (t >= TOPS) return ST_NO_SPACE;
         leaf = first_set(leaf_bits[t], 0, LEAVES);
         if (leaf >= LEAVES) return ST_NO_SPACE;
      end
      bin = (t << 3) | leaf;
      node = bin_head[bin];
      if (node >= NIL_LINK) begin
         node = 0;
         return ST_NO_SPACE;
      end
      whole = span_len[node];
      if (whole < len || node + whole > NIL_LINK) begin
         node = 0;
         return ST_NO_SPACE;
      end
      n = link_next[node];
      if (n > NIL_LINK) n = NIL_LINK;
      bin_head[bin] = n;
      if (n != NIL_LINK) link_prev[n] = NIL_LINK;
      else drop_bin_bit(bin);
      taken[node] = 1'b1;
      if (len > 1) taken[node + len - 1] = 1'b1;
      if (whole > len) push_free(node + len, whole - len);
      return ST_OK;
   endfunction

   function automatic status_type return_region(int node, int len);
      int psz;
      int nb;
      int nsz;
      if (len == 0 || len > MAX_LEN || node + len > NIL_LINK) return ST_BAD_SIZE;
      if (!taken[node]) return ST_DOUBLE_FREE;
      if (node > 0 && !taken[node - 1]) begin
         psz = span_len[node - 1];
         if (psz != 0 && psz <= node) begin
            pull_free(node - psz);
            len += psz;
            node -= psz;
         end
      end
      if (node + len < NIL_LINK && !taken[node + len]) begin
         nb = node + len;
         nsz = span_len[nb];
         if (nsz != 0 && nb + nsz <= NIL_LINK) begin
            pull_free(nb);
            len += nsz;
         end
      end
      push_free(node, len);
      return ST_OK;
   endfunction

   // Present one item, hold it until taken, then log the predicted outcome.
   task automatic issue(op_type op, int len, int base);
      outcome_type want;
      int node;
      req_operation = op;
      req_size = len[10:0];
      req_release_offset = base[9:0];
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      node = 0;
      if (op == OP_ALLOC) begin
         want.status = grant_region(len, node);
         if (want.status == ST_OK) live_grants.push_back('{node, len});
      end else begin
         want.status = return_region(base, len);
         if (want.status == ST_OK) begin
            foreach (live_grants[i]) begin
               if (live_grants[i].base == base) begin
                  live_grants.delete(i);
                  break;
               end
            end
         end
      end
      want.offset = (op == OP_ALLOC && want.status == ST_OK) ? node[9:0] : 10'd0;
      pending_outcomes.push_back(want);
      @(negedge clock);
      start = 1'b0;
      if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain();
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic release_live(int idx);
      grant_type g;
      g = live_grants[idx];
      issue(OP_RELEASE, g.len, g.base);
   endtask

   // Size checks, double release, full table and the undersized last bin head.
   task automatic test_limits();
      issue(OP_ALLOC, 0, 0);
      issue(OP_ALLOC, 1025, 0);
      issue(OP_ALLOC, 2047, 1023);
      issue(OP_RELEASE, 2, 1023);
      issue(OP_RELEASE, 0, 0);
      issue(OP_RELEASE, 5, 0);
      issue(OP_ALLOC, 1024, 0);
      issue(OP_ALLOC, 1, 0);
      issue(OP_RELEASE, 1024, 0);
      issue(OP_ALLOC, 1, 0);
      issue(OP_ALLOC, 7, 0);
      issue(OP_ALLOC, 8, 0);
      issue(OP_ALLOC, 9, 0);
      // the remaining 999-element region heads the last bin but is too short
      issue(OP_ALLOC, 1000, 0);
      issue(OP_ALLOC, 1024, 0);
   endtask

   // Merge on the right, on both sides and on neither side.
   task automatic test_merges();
      issue(OP_RELEASE, 7, 1);
      issue(OP_RELEASE, 9, 16);
      issue(OP_RELEASE, 8, 8);
      issue(OP_RELEASE, 8, 8);
      issue(OP_RELEASE, 1, 0);
      issue(OP_ALLOC, 1023, 0);
      issue(OP_ALLOC, 1, 0);
      issue(OP_RELEASE, 1, 1023);
      issue(OP_RELEASE, 1023, 0);
   endtask

   // Mostly valid alloc/release traffic with a little malformed noise.
   task automatic test_random(int count);
      int r;
      int len;
      int base;
      int tries;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            case ($urandom_range(0, 3))
               0: issue(OP_ALLOC, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1025, 2047),
                        $urandom_range(0, 1023));
               1: begin
                  base = $urandom_range(0, 1023);
                  issue(OP_RELEASE, $urandom_range(1025 - base, 2047), base);
               end
               2: begin
                  tries = 0;
                  base = $urandom_range(0, 1023);
                  while (taken[base] && tries < 30) begin
                     base = $urandom_range(0, 1023);
                     tries++;
                  end
                  if (taken[base]) issue(OP_RELEASE, 0, base);
                  else issue(OP_RELEASE, $urandom_range(1, 1024 - base), base);
               end
               default: issue(OP_RELEASE, 0, $urandom_range(0, 1023));
            endcase
         end else if (live_grants.size() > 0 && (r < 52 || live_grants.size() > 40)) begin
            release_live($urandom_range(0, live_grants.size() - 1));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 48);
            issue(OP_ALLOC, len, $urandom_range(0, 1023));
         end
      end
   endtask

   // Compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t unexpected result: expected none, actual offset %0d status %0d",
                     $realtime, rsp_region_offset, rsp_status);
            error_count++;
         end else begin
            seen = pending_outcomes.pop_front();
            if (rsp_status !== seen.status) begin
               $display("%0t status mismatch: expected %0d actual %0d",
                        $realtime, seen.status, rsp_status);
               error_count++;
            end
            if (rsp_region_offset !== seen.offset) begin
               $display("%0t offset mismatch: expected %0d actual %0d",
                        $realtime, seen.offset, rsp_region_offset);
               error_count++;
            end
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_CAP) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = 1'b0;
      req_size = '0;
      req_release_offset = '0;
      error_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      clear_shadow();
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_limits();
      test_merges();
      // hold until every prediction has been answered
      drain();
      idle_pct = 15;
      test_random(340);
      drain();
      idle_pct = 48;
      test_random(340);
      idle_pct = 0;
      test_random(340);
      drain();
      repeat (30) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
